>>> hw/rtl/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants of the sprite screen projection block.
// ----------------------------------------------------------------------------
package ssp_pkg;

   // register indexes on the csr port
   localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
   localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
   localparam logic [2:0] REG_HALF_FOV      = 3'd2;
   localparam logic [2:0] REG_MARGIN        = 3'd3;
   localparam logic [2:0] REG_PROJ_DIST     = 3'd4;

   // reset values of the registers
   localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd640;
   localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd480;
   localparam logic [13:0] RST_HALF_FOV      = 14'd5461;
   localparam logic [11:0] RST_MARGIN        = 12'd2086;
   localparam logic [19:0] RST_PROJ_DIST     = 20'd141891;

   // cordic gain compensation, q16, and the largest distance code
   localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
   localparam logic [24:0] DIST_MAX     = 25'h1FFFFFF;
   localparam logic [23:0] HALF_TURN24  = 24'h800000;
   localparam int          MAX_STEPS    = 24;

   // arctangent of 2^-i, 2^24 units per turn
   localparam logic [23:0] CORDIC_ATAN [0:MAX_STEPS-1] = '{
      24'd2097152, 24'd1238021, 24'd654136, 24'd332050, 24'd166669, 24'd83416,
      24'd41718,   24'd20860,   24'd10430,  24'd5215,   24'd2608,   24'd1304,
      24'd652,     24'd326,     24'd163,    24'd81,     24'd41,     24'd20,
      24'd10,      24'd5,       24'd3,      24'd1,      24'd1,      24'd0
   };

   typedef struct packed {
      logic [23:0] player_x;
      logic [23:0] player_y;
      logic [15:0] player_heading;
      logic [23:0] sprite_x;
      logic [23:0] sprite_y;
   } ssp_req_type;

   typedef struct packed {
      logic               visible;
      logic [15:0]        abs_relative_angle;
      logic [24:0]        distance;
      logic signed [15:0] screen_offset_x;
      logic [15:0]        sprite_size;
      logic signed [15:0] top_y;
      logic signed [15:0] bottom_y;
      logic [15:0]        left_x;
      logic [12:0]        right_x;
   } ssp_rsp_type;

endpackage

>>> hw/rtl/ssp_if.sv
// ----------------------------------------------------------------------------
// ssp interfaces
// Valid/ready channels for sprite items and projection results.
// ----------------------------------------------------------------------------
interface ssp_req_if;
   logic                valid;
   logic                ready;
   ssp_pkg::ssp_req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ssp_rsp_if;
   logic                valid;
   logic                ready;
   ssp_pkg::ssp_rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/sprite_screen_projection_top.sv
// ----------------------------------------------------------------------------
// sprite_screen_projection_top
// Projects one sprite per transfer onto the screen: bearing and length by a
// vectoring cordic, tangent by a rotation cordic, offset and size by two
// bit-per-stage dividers.
//
//   channel  direction  transfer
//   req      in         player position, heading and sprite position
//   rsp      out        visibility, distance and screen extents
//   csr      in/out     apb register writes and reads
//
// One item per cycle while no result waits untaken. There is one stage per
// cordic step in each cordic and one per quotient bit in the dividers.
// Reset clears the stage valid bits and loads the register defaults.
// When a result waits untaken, the whole pipeline holds; nothing is dropped.
// ----------------------------------------------------------------------------
module sprite_screen_projection_top #(
   parameter int CORDIC_STEPS = 16,
   parameter int TILE_SIZE    = 64
) (
   input  logic        clock,
   input  logic        reset,
   ssp_req_if.sink     req,
   ssp_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ssp_pkg::*;

   localparam int N   = CORDIC_STEPS;
   localparam int VW  = 36;
   localparam int RW  = 33;
   localparam int ZW  = 25;
   localparam int ONW = 52;
   localparam int ODW = 40;
   localparam int SNW = 20 + $clog2(TILE_SIZE + 1);
   localparam int T   = 2 * N + 22;
   localparam logic [SNW-1:0] TILE_K = SNW'(TILE_SIZE);

   typedef struct packed {
      logic signed [VW-1:0] x;
      logic signed [VW-1:0] y;
      logic [23:0]          z;
      logic [15:0]          head;
   } vec_type;

   typedef struct packed {
      logic [50:0]          prod;
      logic                 vis;
      logic [15:0]          absrel;
      logic signed [ZW-1:0] zr;
   } mid_type;

   typedef struct packed {
      logic signed [RW-1:0] x;
      logic signed [RW-1:0] y;
      logic signed [ZW-1:0] z;
      logic [24:0]          sdist;
      logic                 vis;
      logic [15:0]          absrel;
   } rot_type;

   typedef struct packed {
      logic [ONW-1:0] on;
      logic [ODW-1:0] od;
      logic [SNW-1:0] sn;
      logic           cpos;
      logic           sneg;
      logic [24:0]    sdist;
      logic           vis;
      logic [15:0]    absrel;
   } dvs_type;

   typedef struct packed {
      logic [ONW-1:0] orem;
      logic [ODW-1:0] od;
      logic [15:0]    oq;
      logic           osat;
      logic [SNW-1:0] srem;
      logic [24:0]    sd;
      logic [15:0]    sq;
      logic           ssat;
      logic           cpos;
      logic           sneg;
      logic [24:0]    sdist;
      logic           vis;
      logic [15:0]    absrel;
   } div_type;

   // configuration registers
   logic [12:0] width_ff, height_ff;
   logic [13:0] fov_ff;
   logic [11:0] margin_ff;
   logic [19:0] proj_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   // pipeline storage
   vec_type     vec_ff [0:N];
   vec_type     vec_in [0:N];
   mid_type     mid_ff, mid_in;
   rot_type     rot_ff [0:N];
   rot_type     rot_in [0:N];
   dvs_type     dvs_ff, dvs_in;
   div_type     div_ff [0:16];
   div_type     div_in [0:16];
   ssp_rsp_type out_ff, out_in;
   logic [T-1:0] vld_ff, vld_in;
   logic        adv;

   // csr access
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_SCREEN_WIDTH;
         height_ff <= RST_SCREEN_HEIGHT;
         fov_ff    <= RST_HALF_FOV;
         margin_ff <= RST_MARGIN;
         proj_ff   <= RST_PROJ_DIST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_SCREEN_WIDTH:  width_ff  <= csr_pwdata[12:0];
            REG_SCREEN_HEIGHT: height_ff <= csr_pwdata[12:0];
            REG_HALF_FOV:      fov_ff    <= csr_pwdata[13:0];
            REG_MARGIN:        margin_ff <= csr_pwdata[11:0];
            REG_PROJ_DIST:     proj_ff   <= csr_pwdata[19:0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (csr_idx)
         REG_SCREEN_WIDTH:  csr_prdata = {19'd0, width_ff};
         REG_SCREEN_HEIGHT: csr_prdata = {19'd0, height_ff};
         REG_HALF_FOV:      csr_prdata = {18'd0, fov_ff};
         REG_MARGIN:        csr_prdata = {20'd0, margin_ff};
         REG_PROJ_DIST:     csr_prdata = {12'd0, proj_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   // handshake: the pipeline moves when the output slot is free or taken
   assign adv        = !vld_ff[T-1] || rsp.ready;
   assign req.ready  = adv;
   assign vld_in     = {vld_ff[T-2:0], req.valid};
   assign rsp.valid  = vld_ff[T-1];
   assign rsp.payload = out_ff;

   // input: difference vector, folded into the right half plane
   always_comb begin
      logic signed [24:0]   dx, dy;
      logic signed [VW-1:0] x0, y0;
      dx = $signed({1'b0, req.payload.sprite_x}) - $signed({1'b0, req.payload.player_x});
      dy = $signed({1'b0, req.payload.sprite_y}) - $signed({1'b0, req.payload.player_y});
      x0 = {{(VW-33){dx[24]}}, dx, 8'd0};
      y0 = {{(VW-33){dy[24]}}, dy, 8'd0};
      if (dx[24]) begin
         vec_in[0].x = -x0;
         vec_in[0].y = -y0;
         vec_in[0].z = HALF_TURN24;
      end else begin
         vec_in[0].x = x0;
         vec_in[0].y = y0;
         vec_in[0].z = 24'd0;
      end
      vec_in[0].head = req.payload.player_heading;
   end

   // vectoring cordic, one step per stage
   for (genvar i = 0; i < N; i++) begin : g_vec
      always_comb begin
         logic signed [VW-1:0] xs, ys;
         xs = vec_ff[i].x >>> i;
         ys = vec_ff[i].y >>> i;
         vec_in[i+1].head = vec_ff[i].head;
         if (!vec_ff[i].y[VW-1]) begin
            vec_in[i+1].x = vec_ff[i].x + ys;
            vec_in[i+1].y = vec_ff[i].y - xs;
            vec_in[i+1].z = vec_ff[i].z + CORDIC_ATAN[i];
         end else begin
            vec_in[i+1].x = vec_ff[i].x - ys;
            vec_in[i+1].y = vec_ff[i].y + xs;
            vec_in[i+1].z = vec_ff[i].z - CORDIC_ATAN[i];
         end
      end
   end

   // bearing, relative angle, visibility and gain product
   always_comb begin
      logic [23:0]        zr24;
      logic [15:0]        b16, rel;
      logic signed [16:0] phi;
      logic [34:0]        len;
      zr24 = vec_ff[N].z + 24'd128;
      b16  = zr24[23:8];
      rel  = vec_ff[N].head - b16;
      mid_in.absrel = rel[15] ? 16'(-rel) : rel;
      mid_in.vis = {1'b0, mid_in.absrel} < ({3'd0, fov_ff} + {5'd0, margin_ff});
      len = vec_ff[N].x[VW-1] ? 35'd0 : vec_ff[N].x[34:0];
      mid_in.prod = len * INV_GAIN_Q16;
      phi = -$signed({rel[15], rel});
      if (phi > 17'sd16384) begin
         phi = phi - 17'sd32768;
      end else if (phi < -17'sd16384) begin
         phi = phi + 17'sd32768;
      end
      mid_in.zr = {phi[16:0], 8'd0};
   end

   // distance rounding, rotation start
   always_comb begin
      logic [51:0] dsum;
      dsum = {1'b0, mid_ff.prod} + 52'd8388608;
      rot_in[0].sdist  = (dsum[51:24] > {3'd0, DIST_MAX}) ? DIST_MAX : dsum[48:24];
      rot_in[0].x      = RW'(64'sd1073741824);
      rot_in[0].y      = '0;
      rot_in[0].z      = mid_ff.zr;
      rot_in[0].vis    = mid_ff.vis;
      rot_in[0].absrel = mid_ff.absrel;
   end

   // rotation cordic, one step per stage
   for (genvar i = 0; i < N; i++) begin : g_rot
      always_comb begin
         logic signed [RW-1:0] xs, ys;
         logic signed [ZW-1:0] at;
         xs = rot_ff[i].x >>> i;
         ys = rot_ff[i].y >>> i;
         at = $signed({1'b0, CORDIC_ATAN[i]});
         rot_in[i+1].sdist  = rot_ff[i].sdist;
         rot_in[i+1].vis    = rot_ff[i].vis;
         rot_in[i+1].absrel = rot_ff[i].absrel;
         if (!rot_ff[i].z[ZW-1]) begin
            rot_in[i+1].x = rot_ff[i].x - ys;
            rot_in[i+1].y = rot_ff[i].y + xs;
            rot_in[i+1].z = rot_ff[i].z - at;
         end else begin
            rot_in[i+1].x = rot_ff[i].x + ys;
            rot_in[i+1].y = rot_ff[i].y - xs;
            rot_in[i+1].z = rot_ff[i].z + at;
         end
      end
   end

   // numerators and denominators of both divisions
   always_comb begin
      logic signed [RW-1:0] sabs;
      sabs = rot_ff[N].y[RW-1] ? -rot_ff[N].y : rot_ff[N].y;
      dvs_in.sneg   = rot_ff[N].y[RW-1];
      dvs_in.cpos   = !rot_ff[N].x[RW-1] && (rot_ff[N].x != '0);
      dvs_in.on     = sabs[31:0] * proj_ff;
      dvs_in.od     = {rot_ff[N].x[31:0], 8'd0};
      dvs_in.sn     = SNW'(proj_ff) * TILE_K;
      dvs_in.sdist  = rot_ff[N].sdist;
      dvs_in.vis    = rot_ff[N].vis;
      dvs_in.absrel = rot_ff[N].absrel;
   end

   // divider start values and quotient overflow checks
   always_comb begin
      div_in[0].orem   = dvs_ff.on;
      div_in[0].od     = dvs_ff.od;
      div_in[0].oq     = '0;
      div_in[0].osat   = {{(ODW+16-ONW){1'b0}}, dvs_ff.on} >= {dvs_ff.od, 16'd0};
      div_in[0].srem   = dvs_ff.sn;
      div_in[0].sd     = dvs_ff.sdist;
      div_in[0].sq     = '0;
      div_in[0].ssat   = {{(41-SNW){1'b0}}, dvs_ff.sn} >= {dvs_ff.sdist, 16'd0};
      div_in[0].cpos   = dvs_ff.cpos;
      div_in[0].sneg   = dvs_ff.sneg;
      div_in[0].sdist  = dvs_ff.sdist;
      div_in[0].vis    = dvs_ff.vis;
      div_in[0].absrel = dvs_ff.absrel;
   end

   // restoring dividers, one quotient bit per stage
   for (genvar j = 0; j < 16; j++) begin : g_div
      localparam int K = 15 - j;
      always_comb begin
         logic [ODW+14:0] odk, orx;
         logic [39:0]     sdk, srx;
         div_in[j+1] = div_ff[j];
         odk = {15'd0, div_ff[j].od} << K;
         orx = {{(ODW+15-ONW){1'b0}}, div_ff[j].orem};
         if (orx >= odk) begin
            div_in[j+1].orem  = ONW'(orx - odk);
            div_in[j+1].oq[K] = 1'b1;
         end
         sdk = {15'd0, div_ff[j].sd} << K;
         srx = {{(40-SNW){1'b0}}, div_ff[j].srem};
         if (srx >= sdk) begin
            div_in[j+1].srem  = SNW'(srx - sdk);
            div_in[j+1].sq[K] = 1'b1;
         end
      end
   end

   // saturation and screen extents
   always_comb begin
      logic signed [15:0] off;
      logic [15:0]        size;
      logic signed [16:0] top;
      logic signed [17:0] bot, left;
      logic [17:0]        right;
      logic [15:0]        left16;
      if (!div_ff[16].cpos) begin
         off = div_ff[16].sneg ? 16'sh8000 : 16'sh7FFF;
      end else if (div_ff[16].sneg) begin
         off = (div_ff[16].osat || div_ff[16].oq > 16'd32768) ? 16'sh8000
               : $signed(16'(-div_ff[16].oq));
      end else begin
         off = (div_ff[16].osat || div_ff[16].oq > 16'd32767) ? 16'sh7FFF
               : $signed(div_ff[16].oq);
      end
      size  = div_ff[16].ssat ? 16'hFFFF : div_ff[16].sq;
      top   = $signed({5'd0, height_ff[12:1]}) - $signed({2'd0, size[15:1]});
      bot   = {top[16], top} + $signed({2'd0, size});
      if (bot > 18'sd32767) begin
         bot = 18'sd32767;
      end
      left  = $signed({6'd0, width_ff[12:1]}) + {{2{off[15]}}, off};
      left16 = left[17] ? 16'd0 : left[15:0];
      right = {2'd0, left16} + {2'd0, size};
      if (right > {5'd0, width_ff}) begin
         right = {5'd0, width_ff};
      end
      out_in.visible            = div_ff[16].vis;
      out_in.abs_relative_angle = div_ff[16].absrel;
      if (div_ff[16].vis) begin
         out_in.distance        = div_ff[16].sdist;
         out_in.screen_offset_x = off;
         out_in.sprite_size     = size;
         out_in.top_y           = top[15:0];
         out_in.bottom_y        = bot[15:0];
         out_in.left_x          = left16;
         out_in.right_x         = right[12:0];
      end else begin
         out_in.distance        = DIST_MAX;
         out_in.screen_offset_x = '0;
         out_in.sprite_size     = '0;
         out_in.top_y           = '0;
         out_in.bottom_y        = '0;
         out_in.left_x          = '0;
         out_in.right_x         = '0;
      end
   end

   // stage payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i <= N; i++) begin
            vec_ff[i] <= vec_in[i];
            rot_ff[i] <= rot_in[i];
         end
         mid_ff <= mid_in;
         dvs_ff <= dvs_in;
         for (int j = 0; j <= 16; j++) begin
            div_ff[j] <= div_in[j];
         end
         out_ff <= out_in;
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

endmodule

>>> hw/rtl/ssp_checker.sv
// ----------------------------------------------------------------------------
// ssp_checker
// Port-level checks of the sprite screen projection block.
// ----------------------------------------------------------------------------
module ssp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input ssp_pkg::ssp_rsp_type rsp_payload
);
   import ssp_pkg::*;

   // a waiting result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // input is only refused when a result waits untaken
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input refused without output stall");

   // hidden sprites report the far distance and no extents
   a_hidden: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.visible |->
         rsp_payload.distance == DIST_MAX && rsp_payload.sprite_size == 16'd0)
      else $error("hidden sprite with extents");

   // bottom never above top
   a_extent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.visible |-> rsp_payload.bottom_y >= rsp_payload.top_y)
      else $error("bottom above top");

endmodule

bind sprite_screen_projection_top ssp_checker u_ssp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_payload (rsp.payload)
);
